>>> src/hbs_pkg.sv
package hbs_pkg;

  // grid size limit and output queue depth defaults
  localparam int MAX_SIDE_DEF  = 257;
  localparam int OUT_DEPTH_DEF = 8;

  // field widths
  localparam int XW      = 25;
  localparam int CIW     = 17;
  localparam int HW      = 16;
  localparam int RECIP_W = 24;
  localparam int SIDE_W  = 9;
  localparam int CFG_DW  = 24;
  localparam int FRAC_W  = 8;

  // coordinate Q.8 times reciprocal Q.16 gives a Q.24 scaled position
  localparam int SCALE_SH = 24;
  localparam int PW       = XW - 1 + RECIP_W;
  localparam int IXW      = PW - SCALE_SH;

  localparam logic [RECIP_W-1:0] RECIP_RST = 24'd16384;
  localparam logic [SIDE_W-1:0]  SIDE_RST  = 9'd257;

  typedef enum logic {
    CFG_SCALE_RECIP = 1'b0,
    CFG_SIDE        = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // per-item control that travels along the pipeline
  typedef struct packed {
    logic              query;
    logic              ok;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
  } hbs_ctrl_t;

endpackage

>>> src/hbs_ram.sv
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0 <= mem_r[raddr0];
    rdata1 <= mem_r[raddr1];
  end

endmodule

>>> src/hbs_front.sv
module hbs_front
  import hbs_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE),
  localparam int IW = $clog2(MAX_SIDE),
  localparam int SW = $clog2(MAX_SIDE + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  output logic                  ready,
  input  logic                  func,
  input  logic signed [XW-1:0]  x_pos,
  input  logic signed [XW-1:0]  z_pos,
  input  logic [CIW-1:0]        cell_index,
  input  logic [HW-1:0]         height_value,
  input  logic [RECIP_W-1:0]    recip,
  input  logic [SW-1:0]         side,
  input  logic                  m_ready,
  output logic                  vld,
  output hbs_ctrl_t             ctrl,
  output logic [AW-1:0]         base,
  output logic [CIW-1:0]        cidx,
  output logic [HW-1:0]         hval
);

  localparam int SXW = PW - SCALE_SH + FRAC_W;

  // stage 1: scale both coordinates
  logic            p1_vld_r;
  logic            p1_func_r;
  logic            p1_neg_r;
  logic [SXW-1:0]  p1_sx_r;
  logic [SXW-1:0]  p1_sz_r;
  logic [CIW-1:0]  p1_cidx_r;
  logic [HW-1:0]   p1_hval_r;
  logic [PW-1:0]   sx_full;
  logic [PW-1:0]   sz_full;

  // stage 2: range check and flat base address
  logic            p2_vld_r;
  hbs_ctrl_t       p2_ctrl_r;
  hbs_ctrl_t       p2_ctrl_nxt;
  logic [AW-1:0]   p2_base_r;
  logic [AW-1:0]   p2_base_nxt;
  logic [CIW-1:0]  p2_cidx_r;
  logic [HW-1:0]   p2_hval_r;

  logic            p1_ready;
  logic            p2_ready;
  logic [IXW-1:0]  ix;
  logic [IXW-1:0]  iz;
  logic [IXW-1:0]  lim;
  logic [IW+SW-1:0] row_off;

  assign p2_ready = !p2_vld_r || m_ready;
  assign p1_ready = !p1_vld_r || p2_ready;
  assign ready    = p1_ready;

  assign sx_full = PW'(x_pos[XW-2:0]) * PW'(recip);
  assign sz_full = PW'(z_pos[XW-2:0]) * PW'(recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (p1_ready) begin
      p1_vld_r <= fire;
    end
    if (fire) begin
      p1_func_r <= func;
      p1_neg_r  <= x_pos[XW-1] | z_pos[XW-1];
      p1_sx_r   <= sx_full[PW-1:SCALE_SH-FRAC_W];
      p1_sz_r   <= sz_full[PW-1:SCALE_SH-FRAC_W];
      p1_cidx_r <= cell_index;
      p1_hval_r <= height_value;
    end
  end

  assign ix      = p1_sx_r[SXW-1:FRAC_W];
  assign iz      = p1_sz_r[SXW-1:FRAC_W];
  assign lim     = IXW'(side) - IXW'(1);
  assign row_off = iz[IW-1:0] * side;

  always_comb begin
    p2_ctrl_nxt.query = (func_t'(p1_func_r) == FUNC_QUERY);
    p2_ctrl_nxt.ok    = !p1_neg_r && (side >= SW'(2)) && (ix < lim) && (iz < lim);
    p2_ctrl_nxt.fx    = p1_sx_r[FRAC_W-1:0];
    p2_ctrl_nxt.fz    = p1_sz_r[FRAC_W-1:0];
    p2_base_nxt       = AW'(row_off) + AW'(ix[IW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (p2_ready) begin
      p2_vld_r <= p1_vld_r;
    end
    if (p1_vld_r && p2_ready) begin
      p2_ctrl_r <= p2_ctrl_nxt;
      p2_base_r <= p2_base_nxt;
      p2_cidx_r <= p1_cidx_r;
      p2_hval_r <= p1_hval_r;
    end
  end

  assign vld  = p2_vld_r;
  assign ctrl = p2_ctrl_r;
  assign base = p2_base_r;
  assign cidx = p2_cidx_r;
  assign hval = p2_hval_r;

endmodule

>>> src/hbs_interp.sv
module hbs_interp
  import hbs_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld,
  input  hbs_ctrl_t     ctrl,
  input  logic [HW-1:0] h11,
  input  logic [HW-1:0] h12,
  input  logic [HW-1:0] h21,
  input  logic [HW-1:0] h22,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [HW-1:0] out_tdata,  // height_out
  output logic          out_tuser   // in_range
);

  localparam int PTRW = $clog2(OUT_DEPTH);
  localparam int QCW  = $clog2(OUT_DEPTH + 1);
  localparam int AXW  = HW + FRAC_W;
  localparam int RW   = HW + 2 * FRAC_W;

  typedef struct packed {
    logic          in_range;
    logic [HW-1:0] height;
  } res_t;

  // x pass
  logic signed [HW:0]           dx_a;
  logic signed [HW:0]           dx_b;
  logic signed [HW+FRAC_W+1:0]  px_a;
  logic signed [HW+FRAC_W+1:0]  px_b;
  logic signed [HW+FRAC_W+1:0]  sum_a;
  logic signed [HW+FRAC_W+1:0]  sum_b;
  logic                         l_vld_r;
  logic                         l_ok_r;
  logic [FRAC_W-1:0]            l_fz_r;
  logic [AXW-1:0]               l_a_r;
  logic [AXW-1:0]               l_b_r;

  // z pass
  logic signed [AXW:0]          dz;
  logic signed [RW+1:0]         pz;
  logic signed [RW+1:0]         sum_z;
  res_t                         res_nxt;

  // result queue
  res_t                         q_r [OUT_DEPTH];
  logic [PTRW-1:0]              wp_r;
  logic [PTRW-1:0]              rp_r;
  logic [QCW-1:0]               qcnt_r;
  logic                         push;
  logic                         pop;

  assign dx_a  = $signed({1'b0, h12}) - $signed({1'b0, h11});
  assign dx_b  = $signed({1'b0, h22}) - $signed({1'b0, h21});
  assign px_a  = dx_a * $signed({1'b0, ctrl.fx});
  assign px_b  = dx_b * $signed({1'b0, ctrl.fx});
  assign sum_a = $signed({2'b00, h11, {FRAC_W{1'b0}}}) + px_a;
  assign sum_b = $signed({2'b00, h21, {FRAC_W{1'b0}}}) + px_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r <= 1'b0;
    end else begin
      l_vld_r <= vld;
    end
    if (vld) begin
      l_ok_r <= ctrl.ok;
      l_fz_r <= ctrl.fz;
      l_a_r  <= sum_a[AXW-1:0];
      l_b_r  <= sum_b[AXW-1:0];
    end
  end

  assign dz    = $signed({1'b0, l_b_r}) - $signed({1'b0, l_a_r});
  assign pz    = dz * $signed({1'b0, l_fz_r});
  assign sum_z = $signed({2'b00, l_a_r, {FRAC_W{1'b0}}}) + pz;

  always_comb begin
    res_nxt.in_range = l_ok_r;
    res_nxt.height   = l_ok_r ? sum_z[RW-1:2*FRAC_W] : '0;
  end

  assign push = l_vld_r;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTRW'(OUT_DEPTH - 1)) ? '0 : wp_r + PTRW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PTRW'(OUT_DEPTH - 1)) ? '0 : rp_r + PTRW'(1);
      end
      qcnt_r <= qcnt_r + QCW'(push) - QCW'(pop);
    end
  end

  assign out_tvalid = (qcnt_r != '0);
  assign out_tdata  = q_r[rp_r].height;
  assign out_tuser  = q_r[rp_r].in_range;

  // upstream credit keeps a slot free for every result in flight
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (qcnt_r < QCW'(OUT_DEPTH)))
    else $error("result queue overflow");

endmodule

>>> src/heightmap_bilinear_sampler.sv
// path: a query's result beat is registered through the front stages, the memory stage,
//   the corner hold and the interpolator, then waits in an OUT_DEPTH-entry queue
// throughput: an in-range query reads the top row, then the bottom row, as the store
//   has two read ports for four corners; one write per cycle when not stalled
// reset: synchronous, clears pipeline valids, queue pointers and credits, sets config
//   registers to their defaults; the height store is not cleared
module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [87:0]       in_tdata,   // x_pos, z_pos, cell_index, height_value, zero pad
  input  logic              in_tuser,   // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [HW-1:0]     out_tdata,  // height_out
  output logic              out_tuser,  // in_range
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = (SW > SIDE_W) ? SW : SIDE_W;
  localparam int CNTW  = $clog2(OUT_DEPTH + 1);

  logic [RECIP_W-1:0] recip_r;
  logic [SIDE_W-1:0]  side_r;
  logic [CW-1:0]      side_cfg_ext;
  logic [SW-1:0]      side_eff;

  logic               in_fire;
  logic               out_fire;
  logic               f_ready;
  logic               f_vld;
  hbs_ctrl_t          f_ctrl;
  logic [AW-1:0]      f_base;
  logic [CIW-1:0]     f_cidx;
  logic [HW-1:0]      f_hval;

  // memory stage
  logic               m_vld_r;
  logic               m_ph_r;
  hbs_ctrl_t          m_ctrl_r;
  logic [AW-1:0]      m_base_r;
  logic [CIW-1:0]     m_cidx_r;
  logic [HW-1:0]      m_hval_r;
  logic               m_last;
  logic               m_ready;
  logic               m_rd;

  logic               ram_we;
  logic [AW-1:0]      ra0;
  logic [AW-1:0]      ra1;
  logic [HW-1:0]      rd0;
  logic [HW-1:0]      rd1;

  logic               rd0_r;
  logic [HW-1:0]      lo_a_r;
  logic [HW-1:0]      lo_b_r;
  logic               e1_vld_r;
  hbs_ctrl_t          e1_ctrl_r;

  logic [CNTW-1:0]    cnt_r;
  logic [CNTW-1:0]    cnt_nxt;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r <= RECIP_RST;
      side_r  <= SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE_RECIP: recip_r <= cfg_wdata[RECIP_W-1:0];
        CFG_SIDE:        side_r  <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign side_cfg_ext = CW'(side_r);
  assign side_eff     = (side_cfg_ext > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(side_cfg_ext);

  // queries in flight or queued, so the output queue never overflows
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = f_ready && (cnt_r < CNTW'(OUT_DEPTH));
  assign cnt_nxt   = cnt_r + CNTW'(in_fire && (func_t'(in_tuser) == FUNC_QUERY))
                   - CNTW'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  hbs_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .ready        (f_ready),
    .func         (in_tuser),
    .x_pos        (in_tdata[24:0]),
    .z_pos        (in_tdata[49:25]),
    .cell_index   (in_tdata[66:50]),
    .height_value (in_tdata[82:67]),
    .recip        (recip_r),
    .side         (side_eff),
    .m_ready      (m_ready),
    .vld          (f_vld),
    .ctrl         (f_ctrl),
    .base         (f_base),
    .cidx         (f_cidx),
    .hval         (f_hval)
  );

  // an in-range query holds the stage for two reads: top row, then bottom row
  assign m_rd    = m_vld_r && m_ctrl_r.query && m_ctrl_r.ok;
  assign m_last  = !(m_ctrl_r.query && m_ctrl_r.ok) || m_ph_r;
  assign m_ready = !m_vld_r || m_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      m_ph_r  <= 1'b0;
    end else if (m_ready) begin
      m_vld_r <= f_vld;
      m_ph_r  <= 1'b0;
    end else begin
      m_ph_r  <= 1'b1;
    end
    if (f_vld && m_ready) begin
      m_ctrl_r <= f_ctrl;
      m_base_r <= f_base;
      m_cidx_r <= f_cidx;
      m_hval_r <= f_hval;
    end
  end

  assign ram_we = m_vld_r && !m_ctrl_r.query && (32'(m_cidx_r) < 32'(DEPTH));
  assign ra0    = m_ph_r ? (m_base_r + AW'(side_eff)) : m_base_r;
  assign ra1    = ra0 + AW'(1);

  hbs_ram #(
    .WIDTH(HW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (AW'(m_cidx_r)),
    .wdata  (m_hval_r),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // hold the top-row corners while the bottom row is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd0_r    <= 1'b0;
      e1_vld_r <= 1'b0;
    end else begin
      rd0_r    <= m_rd && !m_ph_r;
      e1_vld_r <= m_vld_r && m_last && m_ctrl_r.query;
    end
    if (rd0_r) begin
      lo_a_r <= rd0;
      lo_b_r <= rd1;
    end
    if (m_vld_r && m_last) begin
      e1_ctrl_r <= m_ctrl_r;
    end
  end

  hbs_interp #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld        (e1_vld_r),
    .ctrl       (e1_ctrl_r),
    .h11        (lo_a_r),
    .h12        (lo_b_r),
    .h21        (rd0),
    .h22        (rd1),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (m_rd && !m_ph_r) |=> (m_vld_r && m_ph_r))
    else $error("query left the memory stage after one row");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(OUT_DEPTH))
    else $error("query credit count exceeds queue depth");

  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt_r != '0))
    else $error("result beat without an outstanding query");

endmodule
